@@ design/lis_pkg.sv @@
// lis_pkg: shared types and constants for the longest increasing subsequence block
// no dependencies; imported by lis_front, lis_core and the top level
package lis_pkg;

    localparam int unsigned IN_DATA_W     = 32;
    localparam int unsigned OUT_DATA_W    = 24;
    localparam int unsigned LEN_FIELD_W   = 9;
    localparam int unsigned LEN_FIELD_MAX = 511;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_core_state;

endpackage

@@ design/lis_front.sv @@
// lis_front: input side, takes stream items, forms the compare key and queues them
// depends on lis_pkg
module lis_front #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lis_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,   // element_value
    input  logic                            i_s_axis_tlast,   // last_item
    output logic                            o_q_valid,
    input  logic                            i_q_pop,
    output logic [VALUE_WIDTH-1:0]          o_q_key,
    output logic                            o_q_last
);
    import lis_pkg::*;

    localparam int unsigned QDEPTH = 2;

    logic [VALUE_WIDTH-1:0] r_q_key  [QDEPTH];
    logic                   r_q_last [QDEPTH];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_fill;
    logic [63:0]            w_ext;
    logic [VALUE_WIDTH-1:0] w_key;
    logic                   w_push;
    logic                   w_pop;

    // key is the low VALUE_WIDTH bits, compared signed
    assign w_ext  = 64'(i_s_axis_tdata);
    assign w_key  = w_ext[VALUE_WIDTH-1:0];

    assign o_s_axis_tready = (r_fill != 2'(QDEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_fill != 2'd0);
    assign w_pop           = i_q_pop && o_q_valid;
    assign o_q_key         = r_q_key[r_rd_ptr];
    assign o_q_last        = r_q_last[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_key[r_wr_ptr]  <= w_key;
            r_q_last[r_wr_ptr] <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'(QDEPTH))
        else $error("queue fill above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'(QDEPTH) && !w_pop) |=> (r_fill == 2'(QDEPTH)))
        else $error("queue fill changed while full without pop");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_fill == $past(r_fill) - 2'd1))
        else $error("pop did not lower fill");

endmodule

@@ design/lis_core.sv @@
// lis_core: back end, scans stored elements through one memory read port per cycle
// depends on lis_pkg; holds the value and length memories and the result register
module lis_core #(
    parameter int unsigned MAX_LEN     = 256,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  logic [VALUE_WIDTH-1:0]          i_q_key,
    input  logic                            i_q_last,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [lis_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,   // ending_length, best_length, overflow
    output logic                            o_m_axis_tlast    // sequence_done
);
    import lis_pkg::*;

    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = $clog2(MAX_LEN);

    t_core_state r_state;
    t_core_state n_state;

    logic [VALUE_WIDTH-1:0] r_val_mem [MAX_LEN];
    logic [CW-1:0]          r_len_mem [MAX_LEN];

    logic [VALUE_WIDTH-1:0] r_key;
    logic                   r_last;
    logic                   r_drop;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_best;
    logic                   r_ovf;
    logic [CW-1:0]          r_addr;
    logic                   r_rd_vld;
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic [CW-1:0]          r_rd_len;
    logic [CW-1:0]          r_best_prev;

    logic                   r_out_valid;
    logic [LEN_FIELD_W-1:0] r_out_end;
    logic [LEN_FIELD_W-1:0] r_out_best;
    logic                   r_out_ovf;
    logic                   r_out_last;

    logic                   w_out_free;
    logic                   w_pop;
    logic                   w_rd_en;
    logic                   w_hit;
    logic [CW-1:0]          w_ending;
    logic [CW-1:0]          w_best_new;
    logic                   w_load;

    function automatic logic [LEN_FIELD_W-1:0] sat_len(input logic [CW-1:0] len);
        logic [31:0] wide;
        wide = 32'(len);
        sat_len = (wide > LEN_FIELD_MAX) ? LEN_FIELD_W'(LEN_FIELD_MAX) : wide[LEN_FIELD_W-1:0];
    endfunction

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_rd_en    = (r_state == ST_SCAN) && (r_addr < r_count);
    assign w_hit      = r_rd_vld && ($signed(r_rd_val) < $signed(r_key))
                        && (r_rd_len > r_best_prev);
    assign w_ending   = r_drop ? '0 : r_best_prev + CW'(1);
    assign w_best_new = (w_ending > r_best) ? w_ending : r_best;

    always_comb begin
        n_state = r_state;
        w_pop   = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    w_pop = 1'b1;
                    if ((r_count == CW'(MAX_LEN)) || (r_count == '0)) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_rd_en && !r_rd_vld) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_load  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_q_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load && !r_drop) begin
            r_val_mem[r_count[AW-1:0]] <= r_key;
            r_len_mem[r_count[AW-1:0]] <= w_ending;
        end
        if (w_rd_en) begin
            r_rd_val <= r_val_mem[r_addr[AW-1:0]];
            r_rd_len <= r_len_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_key  <= i_q_key;
            r_last <= i_q_last;
            r_drop <= (r_count == CW'(MAX_LEN));
        end
        if (w_pop) begin
            r_addr      <= '0;
            r_best_prev <= '0;
        end else begin
            if (w_rd_en) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_hit) begin
                r_best_prev <= r_rd_len;
            end
        end
        if (w_load) begin
            r_out_end  <= sat_len(w_ending);
            r_out_best <= sat_len(r_drop ? r_best : w_best_new);
            r_out_ovf  <= r_ovf || r_drop;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                if (r_last) begin
                    r_count <= '0;
                    r_best  <= '0;
                    r_ovf   <= 1'b0;
                end else if (r_drop) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                    r_best  <= w_best_new;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_ovf, r_out_best, r_out_end});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("element count above capacity");

    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_count))
        else $error("scan address past stored elements");

    a_out_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> !r_out_valid)
        else $error("result register overwritten");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_count == '0 && r_best == '0 && !r_ovf))
        else $error("sequence state not cleared after last item");

endmodule

@@ design/longest_increasing_subsequence_top.sv @@
// In the back end each element scans the earlier elements stored in its sequence through the
// single registered read port of the value and length memories, one entry per cycle, and then
// leaves the scan; the first element of a sequence and an element beyond MAX_LEN skip the scan.
// A two-entry input queue and a result register let the input and output sides stall
// independently, and elements beyond MAX_LEN are reported with overflow set.
// Top level: lis_front (input queue) and lis_core (scan engine); depends on lis_pkg
module longest_increasing_subsequence_top #(
    parameter int unsigned MAX_LEN     = 256,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lis_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,   // element_value
    input  logic                            i_s_axis_tlast,   // last_item
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [lis_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,   // ending_length, best_length, overflow
    output logic                            o_m_axis_tlast    // sequence_done
);
    import lis_pkg::*;

    logic                   w_q_valid;
    logic                   w_q_pop;
    logic [VALUE_WIDTH-1:0] w_q_key;
    logic                   w_q_last;

    lis_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_q_valid       (w_q_valid),
        .i_q_pop         (w_q_pop),
        .o_q_key         (w_q_key),
        .o_q_last        (w_q_last)
    );

    lis_core #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .o_q_pop         (w_q_pop),
        .i_q_key         (w_q_key),
        .i_q_last        (w_q_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
